// ===== rtl/twdcm_pkg.sv =====
// Package: shared types and constants of the two-wire debug command master.
package twdcm_pkg;

    // Defaults
    localparam int unsigned MaxDataBytesDef = 3;
    localparam logic [7:0]  HalfPeriodRst   = 8'd1;
    localparam logic [4:0]  MaxPollsRst     = 5'd16;
    localparam logic [4:0]  PollSat         = 5'd31;

    // Stream widths
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMaxPolls   = 2'd1;

    // Sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEND = 3'd1,
        PH_WAIT = 3'd2,
        PH_POLL = 3'd3,
        PH_READ = 3'd4
    } t_phase;

    // One input tick
    typedef struct packed {
        logic       line_in;
        logic [1:0] data_count;
        logic [7:0] data_third;
        logic [7:0] data_second;
        logic [7:0] data_first;
        logic [7:0] command_byte;
        logic       start_req;
    } t_in_item;

    // One result tick
    typedef struct packed {
        logic       ready_seen;
        logic [7:0] response_byte;
        logic       done_res;
        logic       busy_res;
        logic       line_drive;
        logic       line_out;
        logic       clock_out;
    } t_out_item;

    // Configuration registers
    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [4:0] max_ready_polls;
    } t_cfg;

endpackage

// ===== rtl/twdcm_seq.sv =====
// Pin-level sequencer: one tick of the debug port per accepted item.
module twdcm_seq
    import twdcm_pkg::*;
#(
    parameter int unsigned MAX_DATA_BYTES = MaxDataBytesDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    localparam logic [1:0] MaxCnt = 2'(MAX_DATA_BYTES);

    t_phase     r_phase,     n_phase;
    logic [7:0] r_shift,     n_shift;
    logic [2:0] r_bit_cnt,   n_bit_cnt;
    logic [1:0] r_byte_idx,  n_byte_idx;
    logic [1:0] r_held_cnt,  n_held_cnt;
    logic [7:0] r_tick,      n_tick;
    logic [4:0] r_poll,      n_poll;
    logic       r_clk_lvl,   n_clk_lvl;
    logic       r_rdy_flag,  n_rdy_flag;
    logic [7:0] r_held [MAX_DATA_BYTES];

    logic [7:0] in_bytes [3];
    logic [7:0] half;
    logic       tick_last;
    logic       bit_end;
    logic       load;
    logic [7:0] held_sel;

    assign in_bytes[0] = i_item.data_first;
    assign in_bytes[1] = i_item.data_second;
    assign in_bytes[2] = i_item.data_third;

    // Half period of zero acts as one
    assign half      = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign tick_last = ({1'b0, r_tick} + 9'd1) >= {1'b0, half};

    // Pick the next held data byte
    always_comb begin
        held_sel = 8'd0;
        for (int i = 0; i < MAX_DATA_BYTES; i++) begin
            if (r_byte_idx == 2'(i)) held_sel = r_held[i];
        end
    end

    // Next state and result of this tick
    always_comb begin
        n_phase    = r_phase;
        n_shift    = r_shift;
        n_bit_cnt  = r_bit_cnt;
        n_byte_idx = r_byte_idx;
        n_held_cnt = r_held_cnt;
        n_tick     = r_tick;
        n_poll     = r_poll;
        n_clk_lvl  = r_clk_lvl;
        n_rdy_flag = r_rdy_flag;
        load       = 1'b0;
        bit_end    = 1'b0;
        o_res      = '0;
        o_res.line_drive = 1'b1;

        // Bit timer, shared by send, poll and read
        if (r_phase == PH_SEND || r_phase == PH_POLL || r_phase == PH_READ) begin
            if (tick_last) begin
                n_tick = 8'd0;
                if (r_clk_lvl) begin
                    n_clk_lvl = 1'b0;
                end else begin
                    n_clk_lvl = 1'b1;
                    bit_end   = 1'b1;
                end
            end else begin
                n_tick = r_tick + 8'd1;
            end
        end

        unique case (r_phase) inside
            PH_SEND: begin
                o_res.clock_out  = r_clk_lvl;
                o_res.line_out   = r_shift[7];
                o_res.busy_res   = 1'b1;
                if (bit_end) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt = 3'd0;
                        if (r_byte_idx < r_held_cnt) begin
                            n_shift    = held_sel;
                            n_byte_idx = r_byte_idx + 2'd1;
                        end else begin
                            n_phase   = PH_WAIT;
                            n_poll    = 5'd0;
                            n_clk_lvl = 1'b0;
                        end
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                    end
                end
            end
            PH_WAIT: begin
                o_res.line_drive = 1'b0;
                o_res.busy_res   = 1'b1;
                if (!i_item.line_in || r_poll >= i_cfg.max_ready_polls) begin
                    n_rdy_flag = r_poll < i_cfg.max_ready_polls;
                    n_phase    = PH_READ;
                    n_shift    = 8'd0;
                end else begin
                    n_phase = PH_POLL;
                end
                n_bit_cnt = 3'd0;
                n_tick    = 8'd0;
                n_clk_lvl = 1'b1;
            end
            PH_POLL, PH_READ: begin
                o_res.clock_out  = r_clk_lvl;
                o_res.line_drive = 1'b0;
                o_res.busy_res   = 1'b1;
                // Sample on the last tick of the clock-high half
                if (r_phase == PH_READ && r_clk_lvl && tick_last) begin
                    n_shift = {r_shift[6:0], i_item.line_in};
                end
                if (bit_end) begin
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt = 3'd0;
                        n_clk_lvl = 1'b0;
                        if (r_phase == PH_POLL) begin
                            if (r_poll < PollSat) n_poll = r_poll + 5'd1;
                            n_phase = PH_WAIT;
                        end else begin
                            o_res.done_res      = 1'b1;
                            o_res.response_byte = n_shift;
                            o_res.ready_seen    = r_rdy_flag;
                            n_phase             = PH_IDLE;
                        end
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                    end
                end
            end
            default: begin
                n_phase   = PH_IDLE;
                n_clk_lvl = 1'b0;
                if (i_item.start_req) begin
                    load       = 1'b1;
                    n_shift    = i_item.command_byte;
                    n_held_cnt = (i_item.data_count > MaxCnt) ? MaxCnt : i_item.data_count;
                    n_byte_idx = 2'd0;
                    n_bit_cnt  = 3'd0;
                    n_poll     = 5'd0;
                    n_rdy_flag = 1'b0;
                    n_tick     = 8'd0;
                    n_clk_lvl  = 1'b1;
                    n_phase    = PH_SEND;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= 3'd0;
            r_byte_idx <= 2'd0;
            r_held_cnt <= 2'd0;
            r_tick     <= 8'd0;
            r_poll     <= 5'd0;
            r_clk_lvl  <= 1'b0;
            r_rdy_flag <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_idx <= n_byte_idx;
            r_held_cnt <= n_held_cnt;
            r_tick     <= n_tick;
            r_poll     <= n_poll;
            r_clk_lvl  <= n_clk_lvl;
            r_rdy_flag <= n_rdy_flag;
        end
    end

    // Payload: shift register and held data bytes
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift <= n_shift;
            if (load) begin
                for (int i = 0; i < MAX_DATA_BYTES; i++) r_held[i] <= in_bytes[i];
            end
        end
    end

endmodule

// ===== rtl/two_wire_debug_command_master.sv =====
// Top level: stream handshake, config registers and result register.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  one tick of pin inputs (40 bits)
// m_axis    out        m_axis_tvalid / m_axis_tready  one tick of pin outputs (16 bits)
// cfg       in         i_cfg_valid / o_cfg_ready      register index and value
//
// One item in, one result out, one item per cycle while m_axis is not stalled;
// the result register holds the sequencer's single tick of logic for each item.
// Reset is synchronous, active low: sequencer idle, registers at defaults.
// A stalled result holds in the result register; the input side stays open
// in the cycle the result is taken, so a stall on m_axis also holds s_axis.
module two_wire_debug_command_master
    import twdcm_pkg::*;
#(
    parameter int unsigned MAX_DATA_BYTES = MaxDataBytesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_req, command_byte[8], data_first[8], data_second[8], data_third[8],
    // data_count[2], line_in, zero fill
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // clock_out, line_out, line_drive, busy_res, done_res, response_byte[8],
    // ready_seen, zero fill
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    localparam int unsigned ResW = $bits(t_out_item);

    t_cfg      r_cfg;
    t_in_item  in_item;
    t_out_item res;
    t_out_item r_out;
    logic      r_out_valid;
    logic      in_acc;
    logic      cfg_acc;

    assign in_item       = t_in_item'(s_axis_tdata[$bits(t_in_item)-1:0]);
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HalfPeriodRst;
            r_cfg.max_ready_polls   <= MaxPollsRst;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CfgHalfPeriod: r_cfg.half_period_ticks <= i_cfg_data;
                CfgMaxPolls:   r_cfg.max_ready_polls   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    twdcm_seq #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (in_acc),
        .i_item (in_item),
        .i_cfg  (r_cfg),
        .o_res  (res)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_out <= res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW-ResW){1'b0}}, r_out};

    // Checks
    a_acc_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted item left no result");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> r_out.busy_res)
        else $error("done outside a command");

    a_release_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.line_drive) |-> !r_out.line_out)
        else $error("line level set while released");

    a_resp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (r_out.response_byte == 8'd0 && !r_out.ready_seen))
        else $error("response fields set without done");

endmodule

// ===== test/tb_two_wire_debug_command_master.sv =====
// Testbench: streams pin-level ticks into the two-wire debug command master and checks every result tick.
`timescale 1ns / 100ps

module tb_two_wire_debug_command_master;
    import twdcm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Register indexes outside the defined set; writes to them change nothing
    localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_mode;

    // Sequencer mirror: predicts the pin levels of each tick and holds them until they arrive
    class debug_pin_predictor;
        logic [7:0]  half_ticks;
        logic [4:0]  poll_limit;
        t_phase      ph;
        logic [7:0]  shreg;
        logic [2:0]  bitn;
        logic [1:0]  byte_idx;
        logic [7:0]  held [3];
        logic [1:0]  held_n;
        logic [7:0]  ticks;
        logic [4:0]  polls;
        logic        clk_lvl;
        logic        rdy_flag;
        t_out_item   expected_pins [$];
        int unsigned ticks_seen;
        int unsigned dones;
        int unsigned errors;

        function void clear();
            half_ticks = HalfPeriodRst;
            poll_limit = MaxPollsRst;
            ph         = PH_IDLE;
            shreg      = '0;
            bitn       = '0;
            byte_idx   = '0;
            held[0]    = '0;
            held[1]    = '0;
            held[2]    = '0;
            held_n     = '0;
            ticks      = '0;
            polls      = '0;
            clk_lvl    = 1'b0;
            rdy_flag   = 1'b0;
            expected_pins.delete();
            ticks_seen = 0;
            dones      = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            if (idx == CfgHalfPeriod) begin
                half_ticks = val;
            end else if (idx == CfgMaxPolls) begin
                poll_limit = val[4:0];
            end
        endfunction

        function int half_len();
            return (half_ticks == 8'd0) ? 1 : int'(half_ticks);
        endfunction

        // Advance the bit timer; true when a whole bit (high then low half) ends
        function bit bit_step();
            if (int'(ticks) + 1 >= half_len()) begin
                ticks = '0;
                if (clk_lvl) begin
                    clk_lvl = 1'b0;
                    return 1'b0;
                end
                clk_lvl = 1'b1;
                return 1'b1;
            end
            ticks = ticks + 8'd1;
            return 1'b0;
        endfunction

        // Work out the pins for one accepted tick and queue them
        function void note_tick(t_in_item it);
            t_out_item e;
            logic [1:0] n;
            e = '0;
            e.line_drive = 1'b1;
            case (ph) inside
                PH_SEND: begin
                    e.clock_out = clk_lvl;
                    e.line_out  = shreg[7];
                    e.busy_res  = 1'b1;
                    if (bit_step()) begin
                        shreg = shreg << 1;
                        if (bitn == 3'd7) begin
                            bitn = '0;
                            if (byte_idx < held_n && byte_idx < 2'd3) begin
                                shreg    = held[byte_idx];
                                byte_idx = byte_idx + 2'd1;
                            end else begin
                                ph      = PH_WAIT;
                                polls   = '0;
                                clk_lvl = 1'b0;
                            end
                        end else begin
                            bitn = bitn + 3'd1;
                        end
                    end
                end
                PH_WAIT: begin
                    e.line_drive = 1'b0;
                    e.busy_res   = 1'b1;
                    if (!it.line_in || polls >= poll_limit) begin
                        rdy_flag = (polls < poll_limit);
                        ph       = PH_READ;
                        shreg    = '0;
                    end else begin
                        ph = PH_POLL;
                    end
                    bitn    = '0;
                    ticks   = '0;
                    clk_lvl = 1'b1;
                end
                PH_POLL, PH_READ: begin
                    e.clock_out  = clk_lvl;
                    e.line_drive = 1'b0;
                    e.busy_res   = 1'b1;
                    // sample on the last tick of the clock-high half
                    if (ph == PH_READ && clk_lvl && int'(ticks) + 1 >= half_len()) begin
                        shreg = {shreg[6:0], it.line_in};
                    end
                    if (bit_step()) begin
                        if (bitn == 3'd7) begin
                            bitn    = '0;
                            clk_lvl = 1'b0;
                            if (ph == PH_POLL) begin
                                if (polls < PollSat) begin
                                    polls = polls + 5'd1;
                                end
                                ph = PH_WAIT;
                            end else begin
                                e.done_res      = 1'b1;
                                e.response_byte = shreg;
                                e.ready_seen    = rdy_flag;
                                ph              = PH_IDLE;
                            end
                        end else begin
                            bitn = bitn + 3'd1;
                        end
                    end
                end
                default: begin
                    ph      = PH_IDLE;
                    clk_lvl = 1'b0;
                    if (it.start_req) begin
                        n = it.data_count;
                        if (n > MaxDataBytesDef) begin
                            n = 2'(MaxDataBytesDef);
                        end
                        shreg    = it.command_byte;
                        held[0]  = it.data_first;
                        held[1]  = it.data_second;
                        held[2]  = it.data_third;
                        held_n   = n;
                        byte_idx = '0;
                        bitn     = '0;
                        polls    = '0;
                        rdy_flag = 1'b0;
                        ticks    = '0;
                        clk_lvl  = 1'b1;
                        ph       = PH_SEND;
                    end
                end
            endcase
            if (e.done_res) begin
                dones++;
            end
            expected_pins.push_back(e);
            ticks_seen++;
        endfunction

        function void cmp(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // Compare one taken result with the oldest expectation
        function void check_pins(logic [OutDataW-1:0] raw);
            t_out_item e;
            t_out_item g;
            if (expected_pins.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %0h", $time, raw);
                return;
            end
            e = expected_pins.pop_front();
            g = raw[13:0];
            cmp("clock_out", e.clock_out, g.clock_out);
            cmp("line_out", e.line_out, g.line_out);
            cmp("line_drive", e.line_drive, g.line_drive);
            cmp("busy_res", e.busy_res, g.busy_res);
            cmp("done_res", e.done_res, g.done_res);
            cmp("response_byte", e.response_byte, g.response_byte);
            cmp("ready_seen", e.ready_seen, g.ready_seen);
            cmp("fill", 0, raw[15:14]);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    debug_pin_predictor sb;
    int burst_left = 0;
    int unsigned cycles = 0;

    two_wire_debug_command_master u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL two_wire_debug_command_master");
            $finish;
        end
    end

    // Check each result item as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_pins(m_axis_tdata);
        end
    end

    // Stall the result side in spans of changing behavior
    initial begin : rx_stall
        t_rx_mode   mode;
        int         span;
        int         pos;
        logic [7:0] pattern;
        mode    = RX_OPEN;
        span    = 0;
        pos     = 0;
        pattern = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode    = t_rx_mode'($urandom_range(0, 3));
                span    = $urandom_range(16, 96);
                pattern = 8'($urandom_range(1, 255));
            end
            span--;
            pos++;
            case (mode)
                RX_OPEN:    m_axis_tready = 1'b1;
                RX_COIN:    m_axis_tready = 1'($urandom_range(0, 1));
                RX_PATTERN: m_axis_tready = pattern[pos % 8];
                default:    m_axis_tready = (pos % 4 == 0);
            endcase
        end
    end

    function automatic t_in_item rand_tick();
        logic [63:0] r;
        t_in_item it;
        r  = {$urandom, $urandom};
        it = r[35:0];
        return it;
    endfunction

    // Send one item in bursts with random gaps between them
    task automatic push_tick(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
            gap = $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, it};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(it);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (sb.expected_pins.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_timing(input logic [7:0] hp, input logic [7:0] polls);
        settle();
        write_reg(CfgHalfPeriod, hp);
        write_reg(CfgMaxPolls, polls);
    endtask

    // Run one command like a target would: stay busy for a number of dummy
    // bytes, then hand back the reply; other fields are random noise
    task automatic run_command(input logic [7:0] cmd, input logic [7:0] d0,
                               input logic [7:0] d1, input logic [7:0] d2,
                               input logic [1:0] cnt, input int dummies,
                               input logic [7:0] reply);
        t_in_item it;
        it              = rand_tick();
        it.start_req    = 1'b1;
        it.command_byte = cmd;
        it.data_first   = d0;
        it.data_second  = d1;
        it.data_third   = d2;
        it.data_count   = cnt;
        push_tick(it);
        while (sb.ph != PH_IDLE) begin
            it = rand_tick();
            case (sb.ph)
                PH_WAIT: it.line_in = (int'(sb.polls) < dummies);
                PH_READ: it.line_in = reply[3'd7 - sb.bitn];
                default: ;
            endcase
            // flip the line now and then to break the sequence
            if ($urandom_range(0, 31) == 0) begin
                it.line_in = ~it.line_in;
            end
            push_tick(it);
        end
    endtask

    task automatic idle_ticks(input int n);
        t_in_item it;
        repeat (n) begin
            it           = rand_tick();
            it.start_req = 1'b0;
            push_tick(it);
        end
    endtask

    task automatic random_command(input int limit);
        int r;
        int dummies;
        r = $urandom_range(0, 9);
        if (r <= 5) begin
            dummies = 0;
        end else if (r <= 8) begin
            dummies = $urandom_range(1, 3);
        end else begin
            dummies = $urandom_range(0, limit + 1);
        end
        run_command(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    2'($urandom_range(0, 3)), dummies, 8'($urandom));
    endtask

    // Fully random items, then drain until the sequencer is idle again
    task automatic noise_burst();
        repeat ($urandom_range(1, 12)) push_tick(rand_tick());
        while (sb.ph != PH_IDLE) push_tick(rand_tick());
    endtask

    task automatic random_phase(input logic [7:0] hp, input logic [7:0] polls,
                                input int unsigned budget);
        int unsigned first;
        set_timing(hp, polls);
        first = sb.ticks_seen;
        while (sb.ticks_seen - first < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                noise_burst();
            end else begin
                random_command(polls[4:0]);
            end
            idle_ticks($urandom_range(0, 3));
        end
    endtask

    initial begin
        sb = new;
        sb.clear();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed commands at reset timing: empty, all ones, mixed
        run_command(8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 0, 8'h00);
        run_command(8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 0, 8'hFF);
        run_command(8'hA5, 8'h5A, 8'hC3, 8'h3C, 2'd2, 2, 8'h81);
        idle_ticks(3);

        // Small poll limit: time out at the limit
        set_timing(8'd1, 8'd3);
        run_command(8'h3C, 8'h96, 8'h00, 8'hFF, 2'd1, 5, 8'h7E);

        // Poll limit at its top; upper data bits dropped
        set_timing(8'd1, 8'hFF);
        run_command(8'h55, 8'hAA, 8'h01, 8'h80, 2'd0, 2, 8'h55);

        // Zero poll limit: time out at once
        set_timing(8'd2, 8'hE0);
        run_command(8'h81, 8'h7F, 8'hFE, 8'h01, 2'd1, 0, 8'hAA);

        // Zero half period acts as one
        set_timing(8'd0, 8'd1);
        run_command(8'hC0, 8'h03, 8'h30, 8'h0C, 2'd2, 1, 8'h3C);
        run_command(8'h0F, 8'hF0, 8'h11, 8'h22, 2'd3, 0, 8'hC3);

        // Several ticks per half period, one poll before ready
        set_timing(8'd4, 8'd2);
        run_command(8'h96, 8'h69, 8'h00, 8'h00, 2'd0, 1, 8'h5A);

        // Spare register indexes hold nothing
        settle();
        write_reg(CfgSpareLo, 8'hFF);
        write_reg(CfgSpareHi, 8'hA5);
        run_command(8'h12, 8'h34, 8'h56, 8'h78, 2'd0, 0, 8'h9A);

        // Random traffic over several timing settings
        random_phase(8'd1, 8'd16, 100);
        random_phase(8'd1, 8'd1, 60);
        random_phase(8'd2, 8'd31, 60);
        random_phase(8'($urandom_range(1, 3)),
                     {3'($urandom_range(0, 7)), 5'($urandom_range(1, 31))}, 80);
        while (sb.dones < 16) begin
            random_command(31);
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_pins.size() == 0) begin
            $display("PASS two_wire_debug_command_master");
        end else begin
            $display("FAIL two_wire_debug_command_master");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/twdcm_pkg.sv
rtl/twdcm_seq.sv
rtl/two_wire_debug_command_master.sv
test/tb_two_wire_debug_command_master.sv
